FILE: sv/assert_macros.svh
// Assertion macros used by the fixed-point ALU top.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: sv/fxa_pkg.sv
// Types and operation codes of the fixed-point ALU.
// No dependencies.
package fxa_pkg;
	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_LT = 4'd4, OP_LE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
	} op_t;
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF = 2'd1;
	localparam logic [1:0] ERR_DIVZ = 2'd2;
endpackage

FILE: sv/fxa_if.sv
// Valid/ready channel carrying a command or a result item.
// Depends on nothing; payload widths come from parameters.
interface fxa_in_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [3:0] cmd;
	logic signed [W-1:0] operand_a;
	logic signed [W-1:0] operand_b;
	modport source (output valid, cmd, operand_a, operand_b, input ready);
	modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fxa_out_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] result_value;
	logic compare_true;
	logic [1:0] error_code;
	modport source (output valid, result_value, compare_true, error_code, input ready);
	modport sink (input valid, result_value, compare_true, error_code, output ready);
endinterface

FILE: sv/fxa_div.sv
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// Uses fxa_pkg; carries a side payload along the stages.
module fxa_div #(
	parameter int NB = 40,
	parameter int DB = 32,
	parameter int SB = 8
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_v,
	input logic [NB-1:0] num,
	input logic [DB-1:0] den,
	input logic [SB-1:0] side_in,
	output logic out_v,
	output logic [NB-1:0] quo,
	output logic [DB:0] rem,
	output logic [DB-1:0] den_out,
	output logic [SB-1:0] side_out
);
	import fxa_pkg::*;
	logic [NB:1] v_q;
	logic [NB-1:0] n_q [1:NB];
	logic [DB:0] r_q [1:NB];
	logic [DB-1:0] d_q [1:NB];
	logic [SB-1:0] s_q [1:NB];

	for (genvar i = 0; i < NB; i++) begin : g_st
		logic v_in;
		logic [NB-1:0] n_in;
		logic [DB:0] r_in;
		logic [DB-1:0] d_in;
		logic [SB-1:0] s_in;
		logic [DB+1:0] sh;
		logic [DB+1:0] df;
		if (i == 0) begin : g_first
			assign v_in = in_v;
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
			assign s_in = side_in;
		end else begin : g_next
			assign v_in = v_q[i];
			assign n_in = n_q[i];
			assign r_in = r_q[i];
			assign d_in = d_q[i];
			assign s_in = s_q[i];
		end
		assign sh = {r_in, n_in[NB-1]};
		assign df = sh - {2'b0, d_in};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else if (adv) v_q[i+1] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!df[DB+1]) begin
					r_q[i+1] <= df[DB:0];
					n_q[i+1] <= {n_in[NB-2:0], 1'b1};
				end else begin
					r_q[i+1] <= sh[DB:0];
					n_q[i+1] <= {n_in[NB-2:0], 1'b0};
				end
				d_q[i+1] <= d_in;
				s_q[i+1] <= s_in;
			end
		end
	end

	assign out_v = v_q[NB];
	assign quo = n_q[NB];
	assign rem = r_q[NB];
	assign den_out = d_q[NB];
	assign side_out = s_q[NB];
endmodule

FILE: sv/fixed_point_q24_8_alu_top.sv
// Signed Q24.8 fixed-point ALU: add, sub, inc/dec, mul, div, compares, min/max, conversions.
// Every command passes through every stage, so results leave in order.
// Throughput is one item per cycle; a stall holds the whole pipeline in place.
// Decode register, one divider stage per quotient bit, then the output register.
// Reset clears all valid bits; payload registers are not reset.
// Depends on fxa_pkg, fxa_if, fxa_div and assert_macros.svh.
`include "assert_macros.svh"
module fixed_point_q24_8_alu_top #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	fxa_in_if.sink in_ch,
	fxa_out_if.source out_ch
);
	import fxa_pkg::*;
	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int NB = W + F;
	localparam int SB = 4 + 1 + W + 3 + 2 + 1;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	// The whole pipeline moves when the output register is free or being taken.
	logic adv;
	logic out_v_q;
	assign adv = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	// Stage 1: decode, magnitudes, simple ops, and multiply.
	logic v_s1;
	logic [3:0] cmd_s1;
	logic neg_s1, bz_s1;
	logic [W-1:0] ma_s1, mb_s1;
	logic [W-1:0] sval_s1;
	logic scmp_s1;
	logic [1:0] serr_s1;
	logic [2*W-1:0] prod_s1;

	logic [W-1:0] a, b, ma, mb, sum, fi_mag;
	logic [W:0] sm;
	logic lt, gt, ovf;
	logic [W-1:0] sv;
	logic sc;
	logic [1:0] se;
	logic [W+F-1:0] fi_w;

	always_comb begin
		a = in_ch.operand_a;
		b = in_ch.operand_b;
		ma = a[W-1] ? -a : a;
		mb = b[W-1] ? -b : b;
		lt = $signed(a) < $signed(b);
		gt = $signed(b) < $signed(a);
		sv = '0;
		sc = 1'b0;
		se = ERR_NONE;
		sum = '0;
		ovf = 1'b0;
		sm = '0;
		fi_w = {{F{1'b0}}, ma} << F;
		fi_mag = '0;
		case (op_t'(in_ch.cmd))
			OP_ADD, OP_INC, OP_SUB, OP_DEC: begin
				if (in_ch.cmd == OP_ADD) sum = a + b;
				else if (in_ch.cmd == OP_SUB) sum = a - b;
				else if (in_ch.cmd == OP_INC) sum = a + W'(1);
				else sum = a - W'(1);
				if (in_ch.cmd == OP_ADD)
					ovf = (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]);
				else if (in_ch.cmd == OP_SUB)
					ovf = (a[W-1] != b[W-1]) && (sum[W-1] != a[W-1]);
				else if (in_ch.cmd == OP_INC)
					ovf = !a[W-1] && sum[W-1];
				else
					ovf = a[W-1] && !sum[W-1];
				sv = ovf ? (a[W-1] ? MINV : MAXV) : sum;
				se = ovf ? ERR_OVF : ERR_NONE;
			end
			OP_LT: sc = lt;
			OP_LE: sc = !gt;
			OP_GT: sc = gt;
			OP_GE: sc = !lt;
			OP_EQ: sc = a == b;
			OP_NE: sc = a != b;
			OP_MIN: sv = lt ? a : b;
			OP_MAX: sv = gt ? a : b;
			OP_TOINT: begin
				sm = {1'b0, ma} >> F;
				sv = a[W-1] ? -sm[W-1:0] : sm[W-1:0];
			end
			OP_FROMINT: begin
				if (a[W-1]) begin
					ovf = (fi_w > {{F{1'b0}}, MINV});
					sv = ovf ? MINV : -fi_w[W-1:0];
				end else begin
					ovf = (fi_w > {{F{1'b0}}, MAXV});
					sv = ovf ? MAXV : fi_w[W-1:0];
				end
				se = ovf ? ERR_OVF : ERR_NONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= in_ch.cmd;
			neg_s1 <= a[W-1] ^ b[W-1];
			bz_s1 <= (b == '0);
			ma_s1 <= ma;
			mb_s1 <= mb;
			if (in_ch.cmd == OP_DIV) sval_s1 <= a[W-1] ? MINV : MAXV;
			else sval_s1 <= sv;
			scmp_s1 <= sc;
			serr_s1 <= se;
			prod_s1 <= ma * mb;
		end
	end

	// Stage 2 onward: divider with the other results riding along.
	logic [W-1:0] mulv;
	logic [1:0] mule;
	logic [2*W:0] pr;
	logic [2*W-F:0] pq;
	logic [W-1:0] val_in;
	logic [1:0] err_in;
	logic [SB-1:0] side_in, side_out;
	always_comb begin
		pr = {1'b0, prod_s1} + ((2*W+1)'(F > 0) << (F > 0 ? F - 1 : 0));
		pq = pr[2*W:F];
		if (!neg_s1) begin
			mule = (pq > {{(W-F+1){1'b0}}, MAXV}) ? ERR_OVF : ERR_NONE;
			mulv = (mule == ERR_OVF) ? MAXV : pq[W-1:0];
		end else begin
			mule = (pq > {{(W-F+1){1'b0}}, MINV}) ? ERR_OVF : ERR_NONE;
			mulv = (mule == ERR_OVF) ? MINV : -pq[W-1:0];
		end
		if (cmd_s1 == OP_MUL) begin
			val_in = mulv;
			err_in = mule;
		end else begin
			val_in = sval_s1;
			err_in = (cmd_s1 == OP_DIV && bz_s1) ? ERR_DIVZ : serr_s1;
		end
		side_in = {cmd_s1, scmp_s1, val_in, 1'b0, neg_s1, bz_s1, err_in, 1'b0};
	end

	logic dv;
	logic [NB-1:0] quo;
	logic [W:0] rem;
	logic [W-1:0] dden;
	fxa_div #(.NB(NB), .DB(W), .SB(SB)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(v_s1),
		.num({ma_s1, {F{1'b0}}}), .den(bz_s1 ? W'(1) : mb_s1),
		.side_in(side_in), .out_v(dv), .quo(quo), .rem(rem), .den_out(dden),
		.side_out(side_out)
	);

	// Final stage: round the quotient, saturate, pick the result.
	logic [3:0] c_f;
	logic cmp_f, neg_f, bz_f;
	logic [W-1:0] v_f, dval;
	logic [1:0] e_f, derr;
	logic [NB:0] qr;
	logic [W:0] twor;
	always_comb begin
		c_f = side_out[SB-1 -: 4];
		cmp_f = side_out[SB-5];
		v_f = side_out[SB-6 -: W];
		neg_f = side_out[4];
		bz_f = side_out[3];
		e_f = side_out[2:1];
		twor = rem;
		qr = {1'b0, quo} + ((rem >= ({1'b0, dden} - rem)) ? (NB+1)'(1) : '0);
		if (!neg_f) begin
			derr = (qr > {{(NB+1-W){1'b0}}, MAXV}) ? ERR_OVF : ERR_NONE;
			dval = (derr == ERR_OVF) ? MAXV : qr[W-1:0];
		end else begin
			derr = (qr > {{(NB+1-W){1'b0}}, MINV}) ? ERR_OVF : ERR_NONE;
			dval = (derr == ERR_OVF) ? MINV : -qr[W-1:0];
		end
		if (c_f == OP_DIV && !bz_f) begin
			v_f = dval;
			e_f = derr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= dv;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.result_value <= v_f;
			out_ch.compare_true <= cmp_f;
			out_ch.error_code <= e_f;
		end
	end
	assign out_ch.valid = out_v_q;

	logic unused_ok;
	assign unused_ok = ^{twor, side_out[0], side_out[SB-6-W -: 1]};

	// Checks on this block's own control.
	`ASSERT_CLK(a_hold, clk, arst_n, out_v_q && !out_ch.ready |=> out_v_q, "result dropped")
	`ASSERT_CLK(a_err, clk, arst_n, out_v_q |-> out_ch.error_code != 2'd3, "bad error code")
	`ASSERT_CLK(a_cmp, clk, arst_n, out_v_q && out_ch.compare_true |-> out_ch.result_value == '0, "compare value not zero")
	`ASSERT_CLK_RST(a_rst, clk, !arst_n |=> !out_v_q || $past(arst_n), "valid after reset")
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: directed corner items, then random.
// Depends on fxa_pkg, the fxa_in_if / fxa_out_if channel interfaces and fixed_point_q24_8_alu_top.
module testbench;
	import fxa_pkg::*;

	localparam int FB = 8;
	localparam int WB = 32;
	localparam int LATENCY = WB + FB + 3;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] value;
		logic cmp;
		logic [1:0] err;
	} alu_result_t;

	logic clk;
	logic arst_n;
	fxa_in_if #(.W(WB)) in_ch();
	fxa_out_if #(.W(WB)) out_ch();

	fixed_point_q24_8_alu_top #(.FRAC_BITS(FB), .WORD_BITS(WB)) u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	alu_result_t pending_results[$];
	int mismatches;
	longint cycles;
	bit sender_busy_mode;
	bit receiver_busy_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a wide signed value to the word; flag overflow.
	function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
			inout logic [1:0] err);
		if (v > 128'(MAXV)) begin
			err = ERR_OVF;
			return MAXV;
		end
		if (v < 128'(MINV)) begin
			err = ERR_OVF;
			return MINV;
		end
		return v[31:0];
	endfunction

	// Work out the result for one command, with rounding half away from zero.
	function automatic alu_result_t compute_alu(input op_t op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		alu_result_t r;
		logic signed [127:0] wa, wb, w;
		logic [127:0] ma, mb, mag, q, rem;
		logic neg;
		r = '0;
		wa = a;
		wb = b;
		ma = a[31] ? -wa : wa;
		mb = b[31] ? -wb : wb;
		neg = a[31] ^ b[31];
		case (op)
			OP_ADD: r.value = clamp_word(wa + wb, r.err);
			OP_SUB: r.value = clamp_word(wa - wb, r.err);
			OP_MUL: begin
				mag = (ma * mb + (128'd1 << (FB - 1))) >> FB;
				w = neg ? -$signed(mag) : $signed(mag);
				r.value = clamp_word(w, r.err);
			end
			OP_DIV: begin
				if (b == 0) begin
					r.err = ERR_DIVZ;
					r.value = a[31] ? MINV : MAXV;
				end else begin
					q = (ma << FB) / mb;
					rem = (ma << FB) % mb;
					if (rem >= mb - rem)
						q = q + 1;
					w = neg ? -$signed(q) : $signed(q);
					r.value = clamp_word(w, r.err);
				end
			end
			OP_LT: r.cmp = a < b;
			OP_LE: r.cmp = a <= b;
			OP_GT: r.cmp = a > b;
			OP_GE: r.cmp = a >= b;
			OP_EQ: r.cmp = a == b;
			OP_NE: r.cmp = a != b;
			OP_MIN: r.value = (a < b) ? a : b;
			OP_MAX: r.value = (b < a) ? a : b;
			OP_INC: r.value = clamp_word(wa + 1, r.err);
			OP_DEC: r.value = clamp_word(wa - 1, r.err);
			OP_TOINT: begin
				mag = ma >> FB;
				w = a[31] ? -$signed(mag) : $signed(mag);
				r.value = w[31:0];
			end
			default: r.value = clamp_word(wa <<< FB, r.err);
		endcase
		return r;
	endfunction

	// Present one item, hold it until accepted, and queue its expected result.
	// Valid stays high on return so that items can follow back to back.
	task automatic send_item(input op_t op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		while (sender_busy_mode && $urandom_range(99) < 25) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= op;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_results.push_back(compute_alu(op, a, b));
		@(negedge clk);
	endtask

	// Stall the result side at random, except in quiet stretches.
	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= !(receiver_busy_mode && $urandom_range(99) < 25);
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%h cmp=%b err=%0d",
						out_ch.result_value, out_ch.compare_true, out_ch.error_code);
			end else begin
				want = pending_results.pop_front();
				if (want.value !== out_ch.result_value || want.cmp !== out_ch.compare_true
						|| want.err !== out_ch.error_code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
							want.value, want.cmp, want.err, out_ch.result_value,
							out_ch.compare_true, out_ch.error_code);
				end
			end
		end
	end

	// Guard against a hung pipeline.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(7))
			0: return MAXV;
			1: return MINV;
			2: return 32'($signed($urandom_range(512)) - 256);
			3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
			4: return 32'($signed($urandom_range(1 << 16)) - (1 << 15)) <<< FB;
			default: return $urandom;
		endcase
	endfunction

	// Corner operands through every command, the named special cases among them.
	task automatic test_directed();
		op_t op;
		for (int k = 0; k < 16; k++) begin
			op = op_t'(k);
			send_item(op, MAXV, MINV);
		end
		send_item(OP_DIV, 32'sd0, 32'sd0);
		send_item(OP_DIV, -32'sd5, 32'sd0);
		send_item(OP_DIV, MINV, -32'sd256);
		send_item(OP_DIV, 32'sd384, 32'sd512);
		send_item(OP_MUL, -32'sd384, 32'sd1);
		send_item(OP_INC, MAXV, 32'sd0);
		send_item(OP_DEC, MINV, 32'sd0);
		send_item(OP_TOINT, -32'sd257, 32'sd0);
		send_item(OP_EQ, 32'sd7, 32'sd7);
	endtask

	// Random commands and operands, with busy and quiet stretches.
	task automatic test_random();
		for (int n = 0; n < 450; n++) begin
			sender_busy_mode = !(n >= 150 && n < 250);
			receiver_busy_mode = sender_busy_mode;
			send_item(op_t'($urandom_range(15)), pick_operand(), pick_operand());
		end
	endtask

	initial begin
		mismatches = 0;
		cycles = 0;
		sender_busy_mode = 1'b1;
		receiver_busy_mode = 1'b1;
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
